FILE: rtl/ssa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssa_pkg
// Shared types and constants of the swap slot allocator.
// ----------------------------------------------------------------------------
package ssa_pkg;

    // slot space and bitmap organization
    localparam int MAX_SLOTS = 1024;
    localparam int ROW_W     = 32;                  // bitmap bits per memory row
    localparam int NUM_ROWS  = MAX_SLOTS / ROW_W;
    localparam int ROW_AW    = $clog2(NUM_ROWS);
    localparam int BIT_AW    = $clog2(ROW_W);
    localparam int LIM_W     = BIT_AW + 1;          // bit count 0..ROW_W

    // field widths
    localparam int SLOT_W    = 10;
    localparam int MARK_W    = 11;
    localparam int START_W   = 20;
    localparam int PART_W    = 21;
    localparam int SPS_W     = 7;
    localparam int PROD_W    = MARK_W + SPS_W;
    localparam int CFG_IDX_W = 2;

    // operation codes
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PARTITION_SECTORS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SECTORS_PER_SLOT  = 2'd1;

    localparam logic [PART_W-1:0] PART_RESET = 21'd0;
    localparam logic [SPS_W-1:0]  SPS_RESET  = 7'd8;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_BAD_FREE = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        FSM_IDLE,
        FSM_SCAN,
        FSM_FREE_CHK,
        FSM_RECL,
        FSM_MUL,
        FSM_FIT,
        FSM_EMIT
    } fsm_t;

endpackage

FILE: rtl/ssa_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssa_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module ssa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/swap_slot_allocator_top.sv
`timescale 1ns / 1ps
// A free at or above the mark is answered from idle; other frees read their
// bitmap row first, and freeing the top slot walks down the rows it reclaims.
// Allocate reuses the lowest free slot found by a row scan, else fits a fresh one.
// One word at a time: the bitmap memory's single read port and the walk over
// its 32 rows set the rate; the next word is taken once the result is taken.
// Reset: synchronous; row valid flops make the bitmap read as all clear at once.
// ----------------------------------------------------------------------------
// swap_slot_allocator_top
// Swap slot allocator: lowest-free bitmap in RAM with a high-water mark.
// ----------------------------------------------------------------------------
module swap_slot_allocator_top (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [20:0] cfg_data,
    // request stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [9:0] slot_index, [15:10] zero
    input  logic        s_tuser,   // [0] op
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [9:0] granted_slot, [29:10] start_sector,
                                   // [40:30] high_water, [47:41] zero
    output logic [1:0]  m_tuser    // [1:0] status
);

    localparam int ROW_W  = ssa_pkg::ROW_W;
    localparam int ROW_AW = ssa_pkg::ROW_AW;
    localparam int BIT_AW = ssa_pkg::BIT_AW;
    localparam int LIM_W  = ssa_pkg::LIM_W;

    // lowest set bit of a row
    function automatic logic [BIT_AW-1:0] lowest_set(input logic [ROW_W-1:0] bits);
        logic [BIT_AW-1:0] b;
        b = '0;
        for (int i = ROW_W - 1; i >= 0; i--) begin
            if (bits[i]) b = BIT_AW'(i);
        end
        return b;
    endfunction

    // base of the run of set bits that ends just below lim
    function automatic logic [LIM_W-1:0] run_base(input logic [ROW_W-1:0] bits,
                                                  input logic [LIM_W-1:0] lim);
        logic [LIM_W-1:0] k;
        k = '0;
        for (int i = 0; i < ROW_W; i++) begin
            if (LIM_W'(i) < lim && !bits[i]) k = LIM_W'(i + 1);
        end
        return k;
    endfunction

    // state
    ssa_pkg::fsm_t                 state_reg, state_next;
    logic [ssa_pkg::MARK_W-1:0]    mark_reg, mark_next;
    logic [ssa_pkg::MARK_W-1:0]    fcnt_reg, fcnt_next;
    logic [ssa_pkg::SLOT_W-1:0]    slot_reg, slot_next;
    logic [ROW_AW-1:0]             row_reg, row_next;
    logic [LIM_W-1:0]              lim_reg, lim_next;
    logic [ssa_pkg::MARK_W-1:0]    mul_a_reg, mul_a_next;
    logic [ssa_pkg::PROD_W-1:0]    prod_reg, prod_next;
    logic                          fit_pend_reg, fit_pend_next;
    logic [ssa_pkg::NUM_ROWS-1:0]  row_vld_reg;
    logic [ssa_pkg::PART_W-1:0]    part_reg;
    logic [ssa_pkg::SPS_W-1:0]     sps_reg;

    // output word
    logic                          out_vld_reg;
    ssa_pkg::status_t              out_status_reg, out_status_next;
    logic [ssa_pkg::SLOT_W-1:0]    out_slot_reg, out_slot_next;
    logic [ssa_pkg::START_W-1:0]   out_start_reg, out_start_next;
    logic [ssa_pkg::MARK_W-1:0]    out_hw_reg;
    logic                          out_ld;

    // bitmap memory
    logic                          ram_wr_en, ram_rd_en;
    logic [ROW_AW-1:0]             ram_wr_addr, ram_rd_addr;
    logic [ROW_W-1:0]              ram_wr_data, ram_rd_data;
    logic [ROW_W-1:0]              row_bits;

    logic                          s_acc;
    logic [ssa_pkg::SLOT_W-1:0]    s_idx;
    logic [BIT_AW-1:0]             low_bit;
    logic [LIM_W-1:0]              base;
    logic [ROW_W-1:0]              keep_mask;
    logic [LIM_W-1:0]              free_lim;

    ssa_ram #(
        .WIDTH (ROW_W),
        .DEPTH (ssa_pkg::NUM_ROWS)
    ) u_map_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ssa_pkg::FSM_IDLE) && !out_vld_reg;
    assign s_acc     = s_tvalid && s_tready;
    assign s_idx     = s_tdata[ssa_pkg::SLOT_W-1:0];

    // a row never written reads as all clear
    assign row_bits  = row_vld_reg[row_reg] ? ram_rd_data : '0;
    assign low_bit   = lowest_set(row_bits);
    assign free_lim  = (state_reg == ssa_pkg::FSM_FREE_CHK) ?
                       {1'b0, slot_reg[BIT_AW-1:0]} : lim_reg;
    assign base      = run_base(row_bits, free_lim);
    assign keep_mask = ROW_W'(((ROW_W + 1)'(1) << base) - (ROW_W + 1)'(1));

    always_comb begin
        state_next      = state_reg;
        mark_next       = mark_reg;
        fcnt_next       = fcnt_reg;
        slot_next       = slot_reg;
        row_next        = row_reg;
        lim_next        = lim_reg;
        mul_a_next      = mul_a_reg;
        prod_next       = prod_reg;
        fit_pend_next   = fit_pend_reg;
        ram_wr_en       = 1'b0;
        ram_wr_addr     = row_reg;
        ram_wr_data     = row_bits;
        ram_rd_en       = 1'b0;
        ram_rd_addr     = row_reg;
        out_ld          = 1'b0;
        out_status_next = ssa_pkg::ST_OK;
        out_slot_next   = '0;
        out_start_next  = '0;

        unique case (state_reg)
            ssa_pkg::FSM_IDLE: begin
                if (s_acc) begin
                    slot_next = s_idx;
                    if (s_tuser == ssa_pkg::OP_ALLOC) begin
                        if (fcnt_reg != '0) begin
                            ram_rd_en   = 1'b1;
                            ram_rd_addr = '0;
                            row_next    = '0;
                            state_next  = ssa_pkg::FSM_SCAN;
                        end else begin
                            mul_a_next    = mark_reg + 1'b1;
                            fit_pend_next = 1'b1;
                            state_next    = ssa_pkg::FSM_MUL;
                        end
                    end else if ({1'b0, s_idx} >= mark_reg) begin
                        out_ld          = 1'b1;
                        out_status_next = ssa_pkg::ST_BAD_FREE;
                    end else begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = s_idx[ssa_pkg::SLOT_W-1 -: ROW_AW];
                        row_next    = s_idx[ssa_pkg::SLOT_W-1 -: ROW_AW];
                        state_next  = ssa_pkg::FSM_FREE_CHK;
                    end
                end
            end

            ssa_pkg::FSM_SCAN: begin
                if (row_bits != '0) begin
                    ram_wr_en   = 1'b1;
                    ram_wr_data = row_bits & ~(ROW_W'(1) << low_bit);
                    fcnt_next   = fcnt_reg - 1'b1;
                    slot_next   = {row_reg, low_bit};
                    mul_a_next  = {1'b0, row_reg, low_bit};
                    state_next  = ssa_pkg::FSM_MUL;
                end else begin
                    // advance to the next row
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = row_reg + 1'b1;
                    row_next    = row_reg + 1'b1;
                end
            end

            ssa_pkg::FSM_FREE_CHK: begin
                if (row_bits[slot_reg[BIT_AW-1:0]]) begin
                    out_ld          = 1'b1;
                    out_status_next = ssa_pkg::ST_BAD_FREE;
                    state_next      = ssa_pkg::FSM_IDLE;
                end else if ({1'b0, slot_reg} + 1'b1 == mark_reg) begin
                    // top slot: lower the mark through the free run beneath it
                    ram_wr_en   = 1'b1;
                    ram_wr_data = row_bits & keep_mask;
                    fcnt_next   = fcnt_reg - ssa_pkg::MARK_W'(free_lim - base);
                    mark_next   = {1'b0, row_reg, BIT_AW'(0)} + ssa_pkg::MARK_W'(base);
                    if (base == '0 && row_reg != '0) begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = row_reg - 1'b1;
                        row_next    = row_reg - 1'b1;
                        lim_next    = LIM_W'(ROW_W);
                        state_next  = ssa_pkg::FSM_RECL;
                    end else begin
                        out_ld     = 1'b1;
                        state_next = ssa_pkg::FSM_IDLE;
                    end
                end else begin
                    ram_wr_en   = 1'b1;
                    ram_wr_data = row_bits | (ROW_W'(1) << slot_reg[BIT_AW-1:0]);
                    fcnt_next   = fcnt_reg + 1'b1;
                    out_ld      = 1'b1;
                    state_next  = ssa_pkg::FSM_IDLE;
                end
            end

            ssa_pkg::FSM_RECL: begin
                ram_wr_en   = 1'b1;
                ram_wr_data = row_bits & keep_mask;
                fcnt_next   = fcnt_reg - ssa_pkg::MARK_W'(free_lim - base);
                mark_next   = {1'b0, row_reg, BIT_AW'(0)} + ssa_pkg::MARK_W'(base);
                if (base == '0 && row_reg != '0) begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = row_reg - 1'b1;
                    row_next    = row_reg - 1'b1;
                end else begin
                    out_ld     = 1'b1;
                    state_next = ssa_pkg::FSM_IDLE;
                end
            end

            ssa_pkg::FSM_MUL: begin
                prod_next  = ssa_pkg::PROD_W'(mul_a_reg) * ssa_pkg::PROD_W'(sps_reg);
                state_next = fit_pend_reg ? ssa_pkg::FSM_FIT : ssa_pkg::FSM_EMIT;
            end

            ssa_pkg::FSM_FIT: begin
                fit_pend_next = 1'b0;
                if (!mark_reg[ssa_pkg::MARK_W-1] &&
                    ssa_pkg::PART_W'(prod_reg) <= part_reg) begin
                    slot_next  = mark_reg[ssa_pkg::SLOT_W-1:0];
                    mul_a_next = mark_reg;
                    mark_next  = mark_reg + 1'b1;
                    state_next = ssa_pkg::FSM_MUL;
                end else begin
                    out_ld          = 1'b1;
                    out_status_next = ssa_pkg::ST_FULL;
                    state_next      = ssa_pkg::FSM_IDLE;
                end
            end

            ssa_pkg::FSM_EMIT: begin
                out_ld         = 1'b1;
                out_slot_next  = slot_reg;
                out_start_next = ssa_pkg::START_W'(prod_reg);
                state_next     = ssa_pkg::FSM_IDLE;
            end

            default: begin
                state_next = ssa_pkg::FSM_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ssa_pkg::FSM_IDLE;
            mark_reg     <= '0;
            fcnt_reg     <= '0;
            fit_pend_reg <= 1'b0;
            row_vld_reg  <= '0;
            part_reg     <= ssa_pkg::PART_RESET;
            sps_reg      <= ssa_pkg::SPS_RESET;
            out_vld_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            mark_reg     <= mark_next;
            fcnt_reg     <= fcnt_next;
            fit_pend_reg <= fit_pend_next;
            if (ram_wr_en) begin
                row_vld_reg[ram_wr_addr] <= 1'b1;
            end
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    ssa_pkg::CFG_PARTITION_SECTORS: part_reg <= cfg_data;
                    ssa_pkg::CFG_SECTORS_PER_SLOT:  sps_reg  <= cfg_data[ssa_pkg::SPS_W-1:0];
                    default: ;
                endcase
            end
            if (out_ld) begin
                out_vld_reg <= 1'b1;
            end else if (m_tready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        slot_reg  <= slot_next;
        row_reg   <= row_next;
        lim_reg   <= lim_next;
        mul_a_reg <= mul_a_next;
        prod_reg  <= prod_next;
        if (out_ld) begin
            out_status_reg <= out_status_next;
            out_slot_reg   <= out_slot_next;
            out_start_reg  <= out_start_next;
            out_hw_reg     <= mark_next;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {7'd0, out_hw_reg, out_start_reg, out_slot_reg};

`ifndef SYNTHESIS
    a_fcnt_below_mark: assert property (@(posedge aclk) disable iff (!aresetn)
        fcnt_reg <= mark_reg)
        else $error("free count exceeds high-water mark");

    a_mark_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        mark_reg <= ssa_pkg::MARK_W'(ssa_pkg::MAX_SLOTS))
        else $error("high-water mark beyond slot space");

    a_scan_below_mark: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ssa_pkg::FSM_SCAN) |-> ({1'b0, row_reg, BIT_AW'(0)} < mark_reg))
        else $error("free slot scan ran past the mark");

    a_ready_no_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !m_tvalid)
        else $error("request taken while a result is pending");

    a_full_keeps_mark: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ssa_pkg::FSM_FIT && out_ld) |=> $stable(mark_reg))
        else $error("full allocate changed the mark");
`endif

endmodule

FILE: verif/swap_slot_allocator_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swap_slot_allocator_top_tb
// Self-checking bench for the swap slot allocator. A bit-accurate predictor
// tracks the free bitmap and the high-water mark and queues one expected
// grant per accepted request word. A checker compares every result word
// against the oldest grant. Directed cases cover empty and exhausted
// partitions, reuse, double frees, top-slot reclaim and zero sectors per
// slot. Random traffic runs under several partition settings, then fills
// the slot space to its limit, with random stalls on both streams.
// ----------------------------------------------------------------------------
module swap_slot_allocator_top_tb;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 50;
    localparam int MAX_SLOTS      = ssa_pkg::MAX_SLOTS;
    localparam int SLOT_W         = ssa_pkg::SLOT_W;
    localparam int START_W        = ssa_pkg::START_W;
    localparam int MARK_W         = ssa_pkg::MARK_W;
    localparam int PART_W         = ssa_pkg::PART_W;
    localparam int SPS_W          = ssa_pkg::SPS_W;
    localparam int CFG_IDX_W      = ssa_pkg::CFG_IDX_W;

    typedef struct packed {
        ssa_pkg::status_t        status;
        logic [SLOT_W-1:0]       slot;
        logic [START_W-1:0]      start;
        logic [MARK_W-1:0]       high_water;
    } grant_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [PART_W-1:0]    cfg_data  = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [15:0]          s_tdata   = '0;
    logic                 s_tuser   = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [47:0]          m_tdata;
    logic [1:0]           m_tuser;

    // predictor state
    bit                   free_q [MAX_SLOTS];
    int                   mark_q = 0;
    int                   part_q = int'(ssa_pkg::PART_RESET);
    int                   sps_q  = int'(ssa_pkg::SPS_RESET);

    grant_t               expected_grants [$];
    grant_t               head_grant;
    int                   mismatch_count = 0;
    bit                   quiet = 1'b0;
    int                   stall_left = 0;
    int                   idle_count;

    swap_slot_allocator_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #5 aclk = ~aclk;

    // Compute the grant for one request and advance the bitmap and mark.
    function automatic grant_t predict_grant(input logic op, input logic [SLOT_W-1:0] idx);
        grant_t g;
        int     s;
        int     pick;
        int     prod;
        g        = '0;
        g.status = ssa_pkg::ST_OK;
        pick     = -1;
        if (op == ssa_pkg::OP_ALLOC) begin
            for (s = 0; s < mark_q; s++)
                if (pick < 0 && free_q[s])
                    pick = s;
            if (pick >= 0) begin
                free_q[pick] = 1'b0;
            end else if (mark_q < MAX_SLOTS && (mark_q + 1) * sps_q <= part_q) begin
                pick   = mark_q;
                mark_q = mark_q + 1;
            end
            if (pick >= 0) begin
                prod    = pick * sps_q;
                g.slot  = pick[SLOT_W-1:0];
                g.start = prod[START_W-1:0];
            end else begin
                g.status = ssa_pkg::ST_FULL;
            end
        end else if (int'(idx) >= mark_q || free_q[idx]) begin
            g.status = ssa_pkg::ST_BAD_FREE;
        end else if (int'(idx) + 1 == mark_q) begin
            // drop the top slot and reclaim freed slots directly beneath it
            mark_q = int'(idx);
            while (mark_q > 0 && free_q[mark_q - 1]) begin
                free_q[mark_q - 1] = 1'b0;
                mark_q = mark_q - 1;
            end
        end else begin
            free_q[idx] = 1'b1;
        end
        g.high_water = mark_q[MARK_W-1:0];
        return g;
    endfunction

    task automatic flag_mismatch(input string what, input int got, input int want);
        $display("[%0t] mismatch %s: got %0d, want %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    task automatic send_req(input logic op, input logic [SLOT_W-1:0] idx);
        @(negedge aclk);
        if (!quiet && $urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 8)) @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, idx};
        s_tuser  <= op;
        do begin
            @(posedge aclk);
        end while (!s_tready);
        expected_grants.push_back(predict_grant(op, idx));
        @(negedge aclk);
        s_tvalid <= 1'b0;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [PART_W-1:0] data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        do begin
            @(posedge aclk);
        end while (!cfg_ready);
        case (index)
            ssa_pkg::CFG_PARTITION_SECTORS: part_q = int'(data);
            ssa_pkg::CFG_SECTORS_PER_SLOT:  sps_q  = int'(data[SPS_W-1:0]);
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_drain();
        while (expected_grants.size() != 0)
            @(posedge aclk);
    endtask

    task automatic alloc_req();
        send_req(ssa_pkg::OP_ALLOC, SLOT_W'($urandom_range(0, MAX_SLOTS - 1)));
    endtask

    // Free a slot below the mark, preferring one still in use; with no mark, any slot.
    task automatic free_in_use();
        int idx;
        int tries;
        idx = $urandom_range(0, MAX_SLOTS - 1);
        if (mark_q > 0) begin
            idx = $urandom_range(0, mark_q - 1);
            for (tries = 0; tries < 4; tries++)
                if (free_q[idx])
                    idx = $urandom_range(0, mark_q - 1);
        end
        send_req(ssa_pkg::OP_FREE, idx[SLOT_W-1:0]);
    endtask

    task automatic test_empty_partition();
        alloc_req();
        send_req(ssa_pkg::OP_FREE, 10'd0);
        send_req(ssa_pkg::OP_FREE, 10'h3FF);
    endtask

    task automatic test_exhaust_and_reuse();
        wait_drain();
        write_reg(ssa_pkg::CFG_PARTITION_SECTORS, 21'd24);
        repeat (4) alloc_req();
        send_req(ssa_pkg::OP_FREE, 10'd1);
        send_req(ssa_pkg::OP_FREE, 10'd1);
        alloc_req();
        send_req(ssa_pkg::OP_FREE, 10'd0);
        send_req(ssa_pkg::OP_FREE, 10'd1);
        send_req(ssa_pkg::OP_FREE, 10'd2);
    endtask

    task automatic test_zero_sectors_per_slot();
        wait_drain();
        write_reg(ssa_pkg::CFG_SECTORS_PER_SLOT, 21'd0);
        write_reg(ssa_pkg::CFG_PARTITION_SECTORS, 21'd0);
        repeat (2) alloc_req();
        send_req(ssa_pkg::OP_FREE, 10'd1);
        send_req(ssa_pkg::OP_FREE, 10'd0);
    endtask

    task automatic test_extreme_config();
        wait_drain();
        // unused indexes must leave the settings alone
        write_reg(CFG_IDX_W'(2), PART_W'($urandom));
        write_reg(CFG_IDX_W'(3), PART_W'($urandom));
        write_reg(ssa_pkg::CFG_SECTORS_PER_SLOT, 21'd64);
        write_reg(ssa_pkg::CFG_PARTITION_SECTORS, 21'd1048576);
        repeat (2) alloc_req();
        send_req(ssa_pkg::OP_FREE, 10'd0);
        send_req(ssa_pkg::OP_FREE, 10'd1);
        wait_drain();
        write_reg(ssa_pkg::CFG_SECTORS_PER_SLOT, 21'd127);
        write_reg(ssa_pkg::CFG_PARTITION_SECTORS, 21'h1FFFFF);
        send_req(ssa_pkg::OP_ALLOC, 10'h3FF);
        send_req(ssa_pkg::OP_FREE, 10'd0);
    endtask

    // Build a long run of freed slots under the top, then free the top.
    task automatic test_deep_reclaim();
        int run [$];
        int base;
        int i;
        int j;
        int tmp;
        wait_drain();
        write_reg(ssa_pkg::CFG_SECTORS_PER_SLOT, 21'd1);
        write_reg(ssa_pkg::CFG_PARTITION_SECTORS, 21'd1048576);
        repeat (70) alloc_req();
        base = mark_q - 70;
        for (i = base; i < mark_q - 1; i++)
            if (!free_q[i])
                run.push_back(i);
        for (i = run.size() - 1; i > 0; i--) begin
            j      = $urandom_range(0, i);
            tmp    = run[i];
            run[i] = run[j];
            run[j] = tmp;
        end
        foreach (run[k])
            send_req(ssa_pkg::OP_FREE, run[k][SLOT_W-1:0]);
        tmp = mark_q - 1;
        send_req(ssa_pkg::OP_FREE, tmp[SLOT_W-1:0]);
    endtask

    task automatic test_random_churn(input logic [PART_W-1:0] part, input logic [SPS_W-1:0] sps,
                                     input int count, input int alloc_pct);
        int n;
        wait_drain();
        write_reg(ssa_pkg::CFG_PARTITION_SECTORS, part);
        write_reg(ssa_pkg::CFG_SECTORS_PER_SLOT, 21'(sps));
        for (n = 0; n < count; n++) begin
            if (!quiet && $urandom_range(0, 49) == 0)
                wait_drain();
            if ($urandom_range(0, 99) < alloc_pct)
                alloc_req();
            else if ($urandom_range(0, 3) != 0)
                free_in_use();
            else
                send_req(ssa_pkg::OP_FREE, SLOT_W'($urandom_range(0, MAX_SLOTS - 1)));
        end
    endtask

    task automatic test_fill_to_max();
        wait_drain();
        write_reg(ssa_pkg::CFG_SECTORS_PER_SLOT, 21'd0);
        write_reg(ssa_pkg::CFG_PARTITION_SECTORS, 21'd0);
        while (mark_q < MAX_SLOTS) begin
            if ($urandom_range(0, 99) < 4)
                free_in_use();
            else
                alloc_req();
        end
        repeat (3) alloc_req();
        send_req(ssa_pkg::OP_FREE, 10'h3FF);
        alloc_req();
    endtask

    always @(negedge aclk) begin
        if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 7);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_grants.size() == 0) begin
                flag_mismatch("result word with no request", int'(m_tuser), -1);
            end else begin
                head_grant = expected_grants.pop_front();
                if (m_tuser !== head_grant.status)
                    flag_mismatch("status", int'(m_tuser), int'(head_grant.status));
                if (m_tdata[9:0] !== head_grant.slot)
                    flag_mismatch("granted_slot", int'(m_tdata[9:0]), int'(head_grant.slot));
                if (m_tdata[29:10] !== head_grant.start)
                    flag_mismatch("start_sector", int'(m_tdata[29:10]), int'(head_grant.start));
                if (m_tdata[40:30] !== head_grant.high_water)
                    flag_mismatch("high_water", int'(m_tdata[40:30]),
                                  int'(head_grant.high_water));
            end
        end
    end

    // Abort when no word moves on any channel for too long.
    initial begin
        idle_count = 0;
        while (idle_count < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                idle_count = 0;
            else
                idle_count++;
        end
        $display("watchdog expired with %0d results outstanding", expected_grants.size());
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_empty_partition();
        test_exhaust_and_reuse();
        test_zero_sectors_per_slot();
        test_extreme_config();
        test_deep_reclaim();
        test_random_churn(PART_W'($urandom_range(40, 400)), SPS_W'($urandom_range(1, 16)), 80, 55);
        test_random_churn(21'h1FFFFF, 7'd127, 70, 50);
        test_random_churn(21'd1048576, 7'd64, 70, 60);
        test_fill_to_max();
        wait_drain();
        quiet = 1'b1;
        test_random_churn(21'd1048575, 7'd1, 80, 45);
        wait_drain();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && expected_grants.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
